[rtl/drt_pkg.sv]
`timescale 1ns / 1ps

package drt_pkg;

	// field widths
	localparam int ADDR_W = 48;
	localparam int NODE_W = 8;
	localparam int KIND_W = 8;
	localparam int HANDLE_W = 32;
	localparam int FUNC_W = 2;
	localparam int STATUS_W = 2;

	localparam int DEF_TABLE_ENTRIES = 16;

	// stream widths, padded to whole bytes
	localparam int IN_BITS = FUNC_W + 3 * ADDR_W + NODE_W + KIND_W + HANDLE_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STATUS_W + 2 * ADDR_W + NODE_W + KIND_W + HANDLE_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// request codes
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RANGE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_HANDLE = 2'd2;

	// reply codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	localparam int ENTRY_W = 2 * ADDR_W + NODE_W + KIND_W + HANDLE_W;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] node;
		logic [ADDR_W-1:0] high;
		logic [ADDR_W-1:0] low;
	} entry_t;

	// control from the sequencer to the select unit
	typedef struct packed {
		logic clear;
		logic valid;
		logic range_mode;
	} sel_ctrl_t;

endpackage

[rtl/drt_table.sv]
`timescale 1ns / 1ps

module drt_table #(
	parameter int DEPTH = drt_pkg::DEF_TABLE_ENTRIES,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_addr,
	input drt_pkg::entry_t wr_data,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_addr,
	output drt_pkg::entry_t rd_data
);

	drt_pkg::entry_t mem_q [DEPTH];
	drt_pkg::entry_t rd_data_q;

	// one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// one registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/drt_select.sv]
`timescale 1ns / 1ps

module drt_select (
	input logic clk,
	input logic arst_n,
	input drt_pkg::sel_ctrl_t ctrl,
	input drt_pkg::entry_t cand,
	input logic [drt_pkg::ADDR_W-1:0] base,
	input logic [drt_pkg::ADDR_W:0] top,
	input logic [drt_pkg::NODE_W-1:0] node,
	input logic [drt_pkg::HANDLE_W-1:0] handle,
	output logic have,
	output drt_pkg::entry_t best
);

	logic have_q;
	drt_pkg::entry_t best_q;
	logic [drt_pkg::NODE_W-1:0] best_dist_q;
	logic [drt_pkg::NODE_W-1:0] node_gap;
	logic match;
	logic low_first;
	logic better;

	// shared compare unit, one candidate per cycle
	always_comb begin
		node_gap = (node > cand.node) ? (node - cand.node) : (cand.node - node);
		low_first = cand.low < best_q.low;
		if (ctrl.range_mode) begin
			match = (cand.low <= base) && ({1'b0, cand.high} >= top);
			better = !have_q || (node_gap < best_dist_q) ||
				((node_gap == best_dist_q) && low_first);
		end else begin
			match = cand.handle == handle;
			better = !have_q || low_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctrl.clear) begin
			have_q <= 1'b0;
		end else if (ctrl.valid && match) begin
			have_q <= 1'b1;
		end
	end

	// best candidate so far, scan order breaks remaining ties
	always_ff @(posedge clk) begin
		if (!ctrl.clear && ctrl.valid && match && better) begin
			best_q <= cand;
			best_dist_q <= node_gap;
		end
	end

	assign have = have_q;
	assign best = best_q;

endmodule

[rtl/dma_engine_range_table_core.sv]
`timescale 1ns / 1ps

// channel | dir | tdata fields, lowest bit first
// s_*     | in  | func, addr_low, addr_high, length, node, kind, handle
// m_*     | out | status, found_low, found_high, found_node, found_kind, found_handle
//
// insert, unused code, lookup on an empty table: the reply state, then the result register
// lookups: one stored entry read per cycle in the scan state, then the drain state for
//   the read register and the select register, then the reply state
// the next item can be taken in the cycle after its result loads the result register
// reset clears the entry count; stored entries are unknown until inserted
// s_tready is high only while idle; a result held by m_tready keeps the next item waiting

module dma_engine_range_table_core #(
	parameter int TABLE_ENTRIES = drt_pkg::DEF_TABLE_ENTRIES
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// func, addr_low, addr_high, length, node, kind, handle, zero pad
	input logic [drt_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status, found_low, found_high, found_node, found_kind, found_handle, zero pad
	output logic [drt_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = drt_pkg::ADDR_W;
	localparam int NW = drt_pkg::NODE_W;
	localparam int KW = drt_pkg::KIND_W;
	localparam int HW = drt_pkg::HANDLE_W;
	localparam int FW = drt_pkg::FUNC_W;
	localparam int SW = drt_pkg::STATUS_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_DRAIN = 4'b0100,
		S_REPLY = 4'b1000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic rd_valid_s1;
	logic [SW-1:0] status_q;
	logic use_best_q;
	logic range_q;
	logic [AW-1:0] base_q;
	logic [AW:0] top_q;
	logic [NW-1:0] node_q;
	logic [HW-1:0] handle_q;
	logic out_valid_q;
	logic [drt_pkg::OUT_TDATA_W-1:0] out_data_q;

	// input unpacking
	logic [FW-1:0] in_func;
	logic [AW-1:0] in_addr_low;
	logic [AW-1:0] in_addr_high;
	logic [AW-1:0] in_length;
	logic [NW-1:0] in_node;
	logic [KW-1:0] in_kind;
	logic [HW-1:0] in_handle;

	assign in_func = s_tdata[FW-1:0];
	assign in_addr_low = s_tdata[FW +: AW];
	assign in_addr_high = s_tdata[FW+AW +: AW];
	assign in_length = s_tdata[FW+2*AW +: AW];
	assign in_node = s_tdata[FW+3*AW +: NW];
	assign in_kind = s_tdata[FW+3*AW+NW +: KW];
	assign in_handle = s_tdata[FW+3*AW+NW+KW +: HW];

	logic accept;
	logic has_room;
	logic scan_last;
	logic reply_go;

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign has_room = count_q < CNT_W'(TABLE_ENTRIES);
	assign scan_last = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign reply_go = (state_q == S_REPLY) && (!out_valid_q || m_tready);

	// entry storage
	drt_pkg::entry_t wr_entry;
	drt_pkg::entry_t rd_entry;

	assign wr_entry = '{handle: in_handle, kind: in_kind, node: in_node,
		high: in_addr_high, low: in_addr_low};

	drt_table #(
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.wr_en(accept && (in_func == drt_pkg::FUNC_INSERT) && has_room),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(wr_entry),
		.rd_en(state_q == S_SCAN),
		.rd_addr(idx_q),
		.rd_data(rd_entry)
	);

	// select unit
	drt_pkg::sel_ctrl_t sel_ctrl;
	logic sel_have;
	drt_pkg::entry_t sel_best;

	assign sel_ctrl = '{clear: accept, valid: rd_valid_s1, range_mode: range_q};

	drt_select u_select (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(sel_ctrl),
		.cand(rd_entry),
		.base(base_q),
		.top(top_q),
		.node(node_q),
		.handle(handle_q),
		.have(sel_have),
		.best(sel_best)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_valid_s1 <= 1'b0;
			status_q <= drt_pkg::ST_OK;
			use_best_q <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						use_best_q <= 1'b0;
						state_q <= S_REPLY;
						if (in_func == drt_pkg::FUNC_INSERT) begin
							if (has_room) begin
								count_q <= count_q + CNT_W'(1);
								status_q <= drt_pkg::ST_OK;
							end else begin
								status_q <= drt_pkg::ST_FULL;
							end
						end else if ((in_func == drt_pkg::FUNC_RANGE) ||
							(in_func == drt_pkg::FUNC_HANDLE)) begin
							status_q <= drt_pkg::ST_NOMATCH;
							if (count_q != '0) begin
								use_best_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end else begin
							status_q <= drt_pkg::ST_NOMATCH;
						end
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_REPLY;
				end
				S_REPLY: begin
					if (reply_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request operands, the lookup top bound is formed once here
	always_ff @(posedge clk) begin
		if (accept) begin
			range_q <= (in_func == drt_pkg::FUNC_RANGE);
			base_q <= in_addr_low;
			top_q <= {1'b0, in_addr_low} + {1'b0, in_length};
			node_q <= in_node;
			handle_q <= in_handle;
		end
	end

	// result register
	logic [SW-1:0] reply_status;
	drt_pkg::entry_t reply_entry;

	always_comb begin
		reply_status = status_q;
		reply_entry = '0;
		if (use_best_q && sel_have) begin
			reply_status = drt_pkg::ST_OK;
			reply_entry = sel_best;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (reply_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (reply_go) begin
			out_data_q <= {(drt_pkg::OUT_TDATA_W - drt_pkg::OUT_BITS)'(0),
				reply_entry.handle, reply_entry.kind, reply_entry.node,
				reply_entry.high, reply_entry.low, reply_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_func == drt_pkg::FUNC_INSERT) && has_room)
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not add an entry");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (count_q != '0))
		else $error("scan over an empty table");

	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_func == drt_pkg::FUNC_INSERT) && !has_room)
		|=> $stable(count_q))
		else $error("full table changed on insert");

endmodule
